>>> rtl/ptsd3_pkg.sv
// ----------------------------------------------------------------------------
// ptsd3_pkg: shared types and constants for the point to segment distance block
// Register indexes, fixed thresholds and the pipeline stage records.
// ----------------------------------------------------------------------------
package ptsd3_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5,
    REG_RADIUS  = 3'd6
  } cfg_reg_t;

  // 0.0001 in units of 2^-32, rounded to nearest.
  localparam logic [65:0] DEGEN_THRESH = 66'd429497;
  localparam logic [30:0] DIST_MAX     = 31'h7FFF_FFFF;
  localparam logic [61:0] RADIUS2_RST  = 62'h1_0000_0000;
  localparam logic [30:0] RADIUS_RST   = 31'd65536;

  // Divider and square root layout.
  localparam int DIV_IT  = 32;
  localparam int DIV_PER = 2;
  localparam int DIV_ST  = DIV_IT / DIV_PER;
  localparam int SQ_IT   = 31;
  localparam int SQ_PER  = 2;
  localparam int SQ_ST   = (SQ_IT + SQ_PER - 1) / SQ_PER;

  // Per-item context that rides along the whole pipeline.
  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] s;
    logic [2:0][31:0] e;
    logic [2:0][31:0] abm;
    logic [2:0][31:0] nr;
    logic [2:0]       abneg;
    logic             fix;
    logic             degen;
  } ctx_t;

  typedef struct packed {
    ctx_t             c;
    logic [2:0][31:0] apm;
    logic [2:0]       apneg;
  } st1_t;

  typedef struct packed {
    ctx_t             c;
    logic [2:0][63:0] sq;
    logic [2:0][63:0] pr;
    logic [2:0]       prneg;
  } st2_t;

  typedef struct packed {
    ctx_t        c;
    logic [65:0] len2;
    logic [65:0] pos;
    logic [65:0] neg;
  } st3_t;

  typedef struct packed {
    ctx_t        c;
    logic [66:0] num;
    logic [65:0] len2;
    logic [31:0] tq;
  } div_t;

  typedef struct packed {
    ctx_t             c;
    logic [2:0][63:0] prod;
  } mul_t;

  typedef struct packed {
    ctx_t             c;
    logic [2:0][63:0] dsq;
  } dsq_t;

  typedef struct packed {
    ctx_t        c;
    logic [61:0] x;
    logic [61:0] res;
    logic        sat;
    logic        hit;
  } sqr_t;

endpackage

>>> rtl/point_to_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// point_to_segment_distance_3d: closest point on a 3D segment, pipelined
// Projects each query point onto the configured segment, clamps the projection
// parameter to [0,1] and reports the nearest point, distance, hit and degenerate flags.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------
//  in_      | slave     | tvalid / tready    | tdata: point_x, point_y, point_z
//  out_     | master    | tvalid / tready    | tdata: nearest x/y/z, distance,
//           |           |                    |        hit, degenerate
//  cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
// The block takes one item in every cycle while the output side does not stall.
// The pipeline holds the 32-step restoring divider for the projection
// parameter and the 31-step integer square root, two steps per pipeline
// stage, but one in the last square root stage.
// Every stage holds a valid bit and advances when it is empty or when the
// stage after it advances, so a stall on the output fills the pipeline from
// the back without losing or repeating an item. Reset clears all valid bits
// and loads the register reset values; there is no clearing pass.
module point_to_segment_distance_3d (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // point_x, point_y, point_z
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,  // nearest_x, nearest_y, nearest_z, distance,
                                    // hit, degenerate, zero fill
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int I_DIV = 3;
  localparam int I_MUL = I_DIV + ptsd3_pkg::DIV_ST + 1;
  localparam int I_NR  = I_MUL + 1;
  localparam int I_DSQ = I_MUL + 2;
  localparam int I_SQ  = I_MUL + 3;
  localparam int N_ST  = I_SQ + ptsd3_pkg::SQ_ST + 1;

  // Configuration registers. The squared radius is kept beside them so the
  // hit compare needs no multiplier in the item path.
  logic [2:0][31:0] start_r;
  logic [2:0][31:0] end_r;
  logic [30:0]      radius_r;
  logic [61:0]      radius2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      end_r     <= '0;
      radius_r  <= ptsd3_pkg::RADIUS_RST;
      radius2_r <= ptsd3_pkg::RADIUS2_RST;
    end else begin
      radius2_r <= radius_r * radius_r;
      if (cfg_we) begin
        case (cfg_index)
          ptsd3_pkg::REG_START_X: start_r[0] <= cfg_wdata;
          ptsd3_pkg::REG_START_Y: start_r[1] <= cfg_wdata;
          ptsd3_pkg::REG_START_Z: start_r[2] <= cfg_wdata;
          ptsd3_pkg::REG_END_X:   end_r[0]   <= cfg_wdata;
          ptsd3_pkg::REG_END_Y:   end_r[1]   <= cfg_wdata;
          ptsd3_pkg::REG_END_Z:   end_r[2]   <= cfg_wdata;
          ptsd3_pkg::REG_RADIUS:  radius_r   <= cfg_wdata[30:0];
          default: ;
        endcase
      end
    end
  end

  // Magnitude of a 33-bit difference of two 32-bit values always fits 32 bits.
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] m;
    m = v[32] ? (33'd0 - v) : v;
    return m[31:0];
  endfunction

  // Stage advance chain: a stage moves when it is empty or its successor moves.
  logic [N_ST-1:0] v_r;
  logic [N_ST-1:0] adv;

  always_comb begin
    adv[N_ST-1] = !v_r[N_ST-1] || out_tready;
    for (int k = N_ST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < N_ST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Pipeline registers and their next values.
  ptsd3_pkg::st1_t s1_r, s1_nxt;
  ptsd3_pkg::st2_t s2_r, s2_nxt;
  ptsd3_pkg::st3_t s3_r, s3_nxt;
  ptsd3_pkg::div_t div_r   [0:ptsd3_pkg::DIV_ST];
  ptsd3_pkg::div_t div_nxt [0:ptsd3_pkg::DIV_ST];
  ptsd3_pkg::mul_t mul_r, mul_nxt;
  ptsd3_pkg::ctx_t nr_r, nr_nxt;
  ptsd3_pkg::dsq_t dsq_r, dsq_nxt;
  ptsd3_pkg::sqr_t sqr_r   [0:ptsd3_pkg::SQ_ST];
  ptsd3_pkg::sqr_t sqr_nxt [0:ptsd3_pkg::SQ_ST];

  // Stage 1: differences from the start point and their magnitudes and signs.
  always_comb begin
    logic [32:0] ab;
    logic [32:0] ap;
    s1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      ab = {end_r[i][31], end_r[i]} - {start_r[i][31], start_r[i]};
      ap = {in_tdata[32*i+31], in_tdata[32*i +: 32]} - {start_r[i][31], start_r[i]};
      s1_nxt.c.p[i]     = in_tdata[32*i +: 32];
      s1_nxt.c.s[i]     = start_r[i];
      s1_nxt.c.e[i]     = end_r[i];
      s1_nxt.c.abm[i]   = mag33(ab);
      s1_nxt.c.abneg[i] = ab[32];
      s1_nxt.apm[i]     = mag33(ap);
      s1_nxt.apneg[i]   = ap[32];
    end
  end

  // Stage 2: squared segment components and dot product terms.
  always_comb begin
    s2_nxt.c = s1_r.c;
    for (int i = 0; i < 3; i++) begin
      s2_nxt.sq[i]    = s1_r.c.abm[i] * s1_r.c.abm[i];
      s2_nxt.pr[i]    = s1_r.c.abm[i] * s1_r.apm[i];
      s2_nxt.prneg[i] = s1_r.c.abneg[i] ^ s1_r.apneg[i];
    end
  end

  // Stage 3: squared length and the positive and negative halves of the dot.
  always_comb begin
    s3_nxt.c    = s2_r.c;
    s3_nxt.len2 = '0;
    s3_nxt.pos  = '0;
    s3_nxt.neg  = '0;
    for (int i = 0; i < 3; i++) begin
      s3_nxt.len2 = s3_nxt.len2 + {2'b00, s2_r.sq[i]};
      if (s2_r.prneg[i]) begin
        s3_nxt.neg = s3_nxt.neg + {2'b00, s2_r.pr[i]};
      end else begin
        s3_nxt.pos = s3_nxt.pos + {2'b00, s2_r.pr[i]};
      end
    end
  end

  // Stage 4: classify. A short segment or a point behind the start clamps to
  // the start; a point beyond the end clamps to the end. Otherwise the
  // numerator goes to the divider.
  // Restoring divider: t = num / len2 to 32 fraction bits, two bits a stage.
  always_comb begin
    logic [65:0] num;
    num = s3_r.pos - s3_r.neg;
    div_nxt[0].c       = s3_r.c;
    div_nxt[0].num     = {1'b0, num};
    div_nxt[0].len2    = s3_r.len2;
    div_nxt[0].tq      = '0;
    div_nxt[0].c.degen = (s3_r.len2 < ptsd3_pkg::DEGEN_THRESH);
    div_nxt[0].c.fix   = 1'b1;
    div_nxt[0].c.nr    = s3_r.c.s;
    if (!div_nxt[0].c.degen && (s3_r.pos > s3_r.neg)) begin
      if (num >= s3_r.len2) begin
        div_nxt[0].c.nr = s3_r.c.e;
      end else begin
        div_nxt[0].c.fix = 1'b0;
      end
    end
    for (int j = 1; j <= ptsd3_pkg::DIV_ST; j++) begin
      div_nxt[j] = div_r[j-1];
      for (int u = 0; u < ptsd3_pkg::DIV_PER; u++) begin
        div_nxt[j].num = {div_nxt[j].num[65:0], 1'b0};
        div_nxt[j].tq  = {div_nxt[j].tq[30:0], 1'b0};
        if (div_nxt[j].num >= {1'b0, div_nxt[j].len2}) begin
          div_nxt[j].num   = div_nxt[j].num - {1'b0, div_nxt[j].len2};
          div_nxt[j].tq[0] = 1'b1;
        end
      end
    end
  end

  // Scale each segment component by t.
  always_comb begin
    mul_nxt.c = div_r[ptsd3_pkg::DIV_ST].c;
    for (int i = 0; i < 3; i++) begin
      mul_nxt.prod[i] = div_r[ptsd3_pkg::DIV_ST].c.abm[i] * div_r[ptsd3_pkg::DIV_ST].tq;
    end
  end

  // Round half away from zero on the magnitude and add to the start point.
  always_comb begin
    logic [64:0] rnd;
    logic [31:0] off;
    nr_nxt = mul_r.c;
    for (int i = 0; i < 3; i++) begin
      rnd = {1'b0, mul_r.prod[i]} + 65'h0_8000_0000;
      off = rnd[63:32];
      if (!mul_r.c.fix) begin
        nr_nxt.nr[i] = mul_r.c.abneg[i] ? (mul_r.c.s[i] - off) : (mul_r.c.s[i] + off);
      end
    end
  end

  // Squared offsets from the query point to the nearest point.
  always_comb begin
    logic [32:0] dv;
    logic [31:0] dm;
    dsq_nxt.c = nr_r;
    for (int i = 0; i < 3; i++) begin
      dv = {nr_r.p[i][31], nr_r.p[i]} - {nr_r.nr[i][31], nr_r.nr[i]};
      dm = mag33(dv);
      dsq_nxt.dsq[i] = dm * dm;
    end
  end

  // Squared distance, saturation and the hit compare on the exact value.
  // Integer square root, digit by digit, two result bits a stage, one in the last.
  always_comb begin
    logic [65:0] d2;
    logic [61:0] bitv;
    int          it;
    d2 = '0;
    for (int i = 0; i < 3; i++) begin
      d2 = d2 + {2'b00, dsq_r.dsq[i]};
    end
    sqr_nxt[0].c   = dsq_r.c;
    sqr_nxt[0].sat = (d2[65:62] != 4'd0);
    sqr_nxt[0].hit = (d2 <= {4'd0, radius2_r});
    sqr_nxt[0].x   = sqr_nxt[0].sat ? '0 : d2[61:0];
    sqr_nxt[0].res = '0;
    for (int j = 1; j <= ptsd3_pkg::SQ_ST; j++) begin
      sqr_nxt[j] = sqr_r[j-1];
      for (int u = 0; u < ptsd3_pkg::SQ_PER; u++) begin
        it = (j - 1) * ptsd3_pkg::SQ_PER + u;
        if (it < ptsd3_pkg::SQ_IT) begin
          bitv = 62'd1 << (60 - 2 * it);
          if (sqr_nxt[j].x >= sqr_nxt[j].res + bitv) begin
            sqr_nxt[j].x   = sqr_nxt[j].x - (sqr_nxt[j].res + bitv);
            sqr_nxt[j].res = (sqr_nxt[j].res >> 1) + bitv;
          end else begin
            sqr_nxt[j].res = sqr_nxt[j].res >> 1;
          end
        end
      end
    end
  end

  // Payload registers load whenever their stage advances.
  always_ff @(posedge clk) begin
    if (adv[0]) s1_r <= s1_nxt;
    if (adv[1]) s2_r <= s2_nxt;
    if (adv[2]) s3_r <= s3_nxt;
    for (int j = 0; j <= ptsd3_pkg::DIV_ST; j++) begin
      if (adv[I_DIV+j]) div_r[j] <= div_nxt[j];
    end
    if (adv[I_MUL]) mul_r <= mul_nxt;
    if (adv[I_NR])  nr_r  <= nr_nxt;
    if (adv[I_DSQ]) dsq_r <= dsq_nxt;
    for (int j = 0; j <= ptsd3_pkg::SQ_ST; j++) begin
      if (adv[I_SQ+j]) sqr_r[j] <= sqr_nxt[j];
    end
  end

  // Result assembly from the last stage.
  logic [30:0] distance;
  assign distance   = sqr_r[ptsd3_pkg::SQ_ST].sat ? ptsd3_pkg::DIST_MAX
                                                  : sqr_r[ptsd3_pkg::SQ_ST].res[30:0];
  assign out_tvalid = v_r[N_ST-1];
  assign out_tdata  = {7'd0,
                       sqr_r[ptsd3_pkg::SQ_ST].c.degen,
                       sqr_r[ptsd3_pkg::SQ_ST].hit,
                       distance,
                       sqr_r[ptsd3_pkg::SQ_ST].c.nr[2],
                       sqr_r[ptsd3_pkg::SQ_ST].c.nr[1],
                       sqr_r[ptsd3_pkg::SQ_ST].c.nr[0]};

`ifndef NO_ASSERTIONS
  // Input is held off only when the output stage is occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v_r[N_ST-1])
    else $error("input stalled while the output stage is empty");

  // Items sent to the divider have a numerator below the squared length.
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[I_DIV] && !div_r[0].c.fix |-> div_r[0].num < {1'b0, div_r[0].len2})
    else $error("divider numerator out of range");

  // A hit never reports a distance beyond the radius.
  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[127] |-> out_tdata[126:96] <= radius_r)
    else $error("hit with distance above radius");

  // A degenerate segment reports the start point as nearest.
  a_degen_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[95:0] == {start_r[2], start_r[1], start_r[0]})
    else $error("degenerate result not at start point");
`endif

endmodule

>>> test/point_to_segment_distance_3d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_segment_distance_3d_tb: self-checking bench for the segment block
// Streams query points through the block under changing segment and radius
// settings, predicts each nearest point, distance, hit and degenerate flag in
// exact wide integer arithmetic, and compares every result item in order.
// ----------------------------------------------------------------------------
module point_to_segment_distance_3d_tb;

  localparam int LATENCY   = 40;
  localparam int CYCLE_CAP = 1000000;
  localparam logic [65:0] SHORT_LEN2 = 66'd429497;

  typedef struct packed {
    logic [31:0] pz;
    logic [31:0] py;
    logic [31:0] px;
  } query_t;

  typedef struct {
    logic [31:0] nx, ny, nz;
    logic [30:0] distance;
    logic        hit, degen;
  } answer_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [95:0]   in_tdata = '0;   // point_x, point_y, point_z
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [135:0]  out_tdata;       // nearest_x/y/z, distance, hit, degenerate
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [31:0]   cfg_wdata = '0;

  point_to_segment_distance_3d u_dut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the segment registers used by the predictor.
  logic signed [31:0] seg_start [3];
  logic signed [31:0] seg_end [3];
  logic [30:0]        coll_radius;

  query_t  pending_points [$];
  answer_t expected_answers [$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles   = 0;
  int      error_count   = 0;
  int      result_count  = 0;
  int      sent_count    = 0;
  int      cycle_count   = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Closest point on the configured segment, computed exactly in wide signed
  // integers, with t quantized to 32 fraction bits as the hardware does.
  function automatic answer_t nearest_on_segment(input query_t q);
    answer_t a;
    logic signed [39:0]  p [3];
    logic signed [39:0]  ab [3];
    logic signed [39:0]  ap [3];
    logic signed [39:0]  nr [3];
    logic signed [39:0]  dv;
    logic signed [79:0]  len2, dotp, d2;
    logic [111:0]        numq;
    logic [79:0]         tq, m, off;
    logic [79:0]         r2;
    p[0] = $signed(q.px); p[1] = $signed(q.py); p[2] = $signed(q.pz);
    len2 = '0; dotp = '0; d2 = '0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = 40'(seg_end[i]) - 40'(seg_start[i]);
      ap[i] = p[i] - 40'(seg_start[i]);
      len2  = len2 + 80'(ab[i]) * 80'(ab[i]);
      dotp  = dotp + 80'(ab[i]) * 80'(ap[i]);
    end
    a.degen = (len2 < 80'(SHORT_LEN2));
    if (a.degen || dotp <= 0) begin
      for (int i = 0; i < 3; i++) nr[i] = seg_start[i];
    end else if (dotp >= len2) begin
      for (int i = 0; i < 3; i++) nr[i] = seg_end[i];
    end else begin
      // The shifted numerator needs more than 80 bits for long segments.
      numq = 112'(dotp) << 32;
      tq   = 80'(numq / 112'(len2));
      for (int i = 0; i < 3; i++) begin
        m   = (ab[i] < 0) ? 80'(-ab[i]) : 80'(ab[i]);
        off = (m * tq + 80'h8000_0000) >> 32;
        nr[i] = (ab[i] < 0) ? 40'(seg_start[i]) - 40'(off) : 40'(seg_start[i]) + 40'(off);
      end
    end
    for (int i = 0; i < 3; i++) begin
      dv = p[i] - nr[i];
      d2 = d2 + 80'(dv) * 80'(dv);
    end
    a.nx = nr[0][31:0]; a.ny = nr[1][31:0]; a.nz = nr[2][31:0];
    a.distance = (d2 >= (80'd1 << 62)) ? ptsd3_pkg::DIST_MAX : 31'(int_sqrt(d2[63:0]));
    r2 = 80'(coll_radius) * 80'(coll_radius);
    a.hit = (80'(d2) <= r2);
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
    error_count++;
  endtask

  // Driver: offers the head of the pending queue, idling at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(nearest_on_segment(query_t'(in_tdata)));
        void'(pending_points.pop_front());
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_points[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counted in its own process.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    answer_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("unexpected result item %h", out_tdata);
          error_count++;
        end else begin
          w = expected_answers.pop_front();
          if (out_tdata[31:0] !== w.nx) report_mismatch("nearest_x", out_tdata[31:0], w.nx);
          if (out_tdata[63:32] !== w.ny) report_mismatch("nearest_y", out_tdata[63:32], w.ny);
          if (out_tdata[95:64] !== w.nz) report_mismatch("nearest_z", out_tdata[95:64], w.nz);
          if (out_tdata[126:96] !== w.distance)
            report_mismatch("distance", 32'(out_tdata[126:96]), 32'(w.distance));
          if (out_tdata[127] !== w.hit) report_mismatch("hit", 32'(out_tdata[127]), 32'(w.hit));
          if (out_tdata[128] !== w.degen)
            report_mismatch("degenerate", 32'(out_tdata[128]), 32'(w.degen));
        end
        result_count++;
      end
      out_tready <= (hold_cycles <= 1) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Registers are written only while the pipeline is empty.
  task automatic write_reg(input ptsd3_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptsd3_pkg::REG_RADIUS) coll_radius = val[30:0];
    else if (idx <= ptsd3_pkg::REG_START_Z) seg_start[int'(idx)] = val;
    else seg_end[int'(idx) - 3] = val;
  endtask

  task automatic set_segment(input logic [31:0] sx, sy, sz, ex, ey, ez,
                             input logic [30:0] r);
    write_reg(ptsd3_pkg::REG_START_X, sx);
    write_reg(ptsd3_pkg::REG_START_Y, sy);
    write_reg(ptsd3_pkg::REG_START_Z, sz);
    write_reg(ptsd3_pkg::REG_END_X, ex);
    write_reg(ptsd3_pkg::REG_END_Y, ey);
    write_reg(ptsd3_pkg::REG_END_Z, ez);
    write_reg(ptsd3_pkg::REG_RADIUS, {1'b0, r});
  endtask

  task automatic drain;
    while (pending_points.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int span);
    // Mostly points near the segment, sometimes anywhere in the range.
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * span)) - span) << 8;
      default: return 32'($signed($urandom_range(2 * span)) - span) << 12;
    endcase
  endfunction

  task automatic add_point(input logic [31:0] x, y, z);
    query_t q;
    q.px = x; q.py = y; q.pz = z;
    pending_points.push_back(q);
  endtask

  initial begin
    seg_start = '{0, 0, 0};
    seg_end   = '{0, 0, 0};
    coll_radius = 31'd65536;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset segment is degenerate, then a unit segment on x with
    // points before, on and past it, exact midpoint rounding and range extremes.
    add_point(32'h0001_0000, 0, 0);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    set_segment(0, 0, 0, 32'h0001_0000, 0, 0, 31'h0000_8000);
    add_point(32'hFFFF_0000, 32'h0000_8000, 0);
    add_point(32'h0000_8000, 32'h0000_8000, 0);
    add_point(32'h0000_8000, 0, 32'h0000_8001);
    add_point(32'h0002_0000, 0, 0);
    add_point(32'h0000_0001, 32'hFFFF_FFFF, 0);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    // Widest possible segment, maximal radius.
    set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    add_point(0, 0, 0);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0003);
    drain();
    // Just below and just above the short-segment threshold, zero radius.
    set_segment(32'h0000_0100, 0, 0, 32'h0000_0100 + 32'd655, 0, 0, 31'd0);
    add_point(32'h0000_0100, 0, 0);
    add_point(32'h0000_0400, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    set_segment(0, 0, 0, 32'd656, 0, 0, 31'd0);
    add_point(32'd300, 0, 0);
    add_point(32'd700, 32'd1, 0);
    drain();

    // Random phases with three idling profiles and fresh segments.
    for (int ph = 0; ph < 9; ph++) begin
      int span;
      span = (ph % 3 == 0) ? 256 : 65536;
      send_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 74 : 0;
      recv_idle_pct = (ph < 3) ? 74 : (ph < 6) ? 16 : 0;
      set_segment(rand_coord(span), rand_coord(span), rand_coord(span),
                  rand_coord(span), rand_coord(span), rand_coord(span),
                  31'($urandom_range(2 * span) << 10));
      if (ph == 4) begin
        hold_cycles = 200;
        for (int i = 0; i < 80; i++)
          add_point(rand_coord(span), rand_coord(span), rand_coord(span));
        drain();
      end
      for (int i = 0; i < 140; i++)
        add_point(rand_coord(span), rand_coord(span), rand_coord(span));
      drain();
    end

    $display("covered %0d query items and %0d results across directed extremes,", sent_count,
             result_count);
    $display("short segments, full-range segments and nine random segment settings");
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
